// ===== rtl/tfdc_pkg.sv =====
// Package for the thermistor fan duty controller.
// Holds widths, fixed-point constants, the sequencer state type and the duty lookup.
// No dependencies.
package tfdc_pkg;

    localparam int ADC_BITS = 12;
    localparam int BYTE_W   = 8;
    localparam int DUTY_W   = 8;
    localparam int TEMP_W   = 22;

    // Divider resistance scale: 10000 ohms with 8 fraction bits.
    localparam int RSCALE_W = 22;
    localparam logic [RSCALE_W-1:0] RSCALE = RSCALE_W'(2560000);

    localparam int NUM_W   = RSCALE_W + ADC_BITS;
    localparam int DEN_W   = ADC_BITS + 1;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int SLOPE_W = 15;
    localparam int PROD_W  = NUM_W + SLOPE_W;
    localparam int Q_W     = PROD_W + 2;
    localparam int FRAC_W  = 28;

    localparam logic [DEN_W-1:0] ADC_FULL = DEN_W'(1) << ADC_BITS;
    localparam logic [ADC_BITS-1:0] LED_THRESH =
        ADC_BITS'((64'd1 << (ADC_BITS - 1)) - 64'd1);

    // Segment bounds on the resistance, 8 fraction bits.
    localparam logic [NUM_W-1:0] R_A_LO = NUM_W'(64'd5933 * 64'd256);
    localparam logic [NUM_W-1:0] R_A_HI = NUM_W'(64'd15698 * 64'd256);
    localparam logic [NUM_W-1:0] R_B_LO = NUM_W'(64'd1919 * 64'd256);

    // Slopes in Q.20, offsets in Q.28.
    localparam logic [SLOPE_W-1:0] SLOPE_A = SLOPE_W'(2307);
    localparam logic [SLOPE_W-1:0] SLOPE_B = SLOPE_W'(7969);
    localparam logic [SLOPE_W-1:0] SLOPE_C = SLOPE_W'(28836);
    localparam logic signed [Q_W-1:0] OFFS_A = Q_W'(64'sd50027561 * 64'sd256);
    localparam logic signed [Q_W-1:0] OFFS_B = Q_W'(64'sd82750472 * 64'sd256);
    localparam logic signed [Q_W-1:0] OFFS_C = Q_W'(64'sd121886474 * 64'sd256);
    localparam logic signed [Q_W-1:0] TRUNC_BIAS = Q_W'((64'sd1 << FRAC_W) - 64'sd1);

    // Stream packing.
    localparam int IN_BITS    = ADC_BITS + BYTE_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = DUTY_W + 1 + BYTE_W + TEMP_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic CMD_ADC  = 1'b0;
    localparam logic CMD_GOAL = 1'b1;

    // Fan duty levels and gap thresholds.
    localparam int GAP_W = TEMP_W + 2;
    localparam logic [DUTY_W-1:0] DUTY_OFF   = DUTY_W'(0);
    localparam logic [DUTY_W-1:0] DUTY_FULL  = DUTY_W'(255);
    localparam logic [DUTY_W-1:0] DUTY_MID   = DUTY_W'(150);
    localparam logic [DUTY_W-1:0] DUTY_LOW   = DUTY_W'(70);
    localparam logic [DUTY_W-1:0] DUTY_BOOST = DUTY_W'(20);
    localparam logic signed [TEMP_W-1:0] COOL_TEMP = TEMP_W'(46);
    localparam logic signed [GAP_W-1:0] GAP_FULL_LO = -GAP_W'(75);
    localparam logic signed [GAP_W-1:0] GAP_FULL_HI = -GAP_W'(3);
    localparam logic signed [GAP_W-1:0] GAP_MID     = -GAP_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_PROD,
        ST_DIFF,
        ST_ROUND,
        ST_DONE
    } state_t;

    function automatic logic [DUTY_W-1:0] fan_level(
        input logic [BYTE_W-1:0]        goal,
        input logic signed [TEMP_W-1:0] temp
    );
        logic signed [GAP_W-1:0] gap;
        logic [DUTY_W-1:0]       extra;
        gap = $signed({{(GAP_W - BYTE_W){1'b0}}, goal})
            - $signed({{(GAP_W - TEMP_W){temp[TEMP_W-1]}}, temp});
        extra = (temp < COOL_TEMP) ? DUTY_BOOST : DUTY_OFF;
        if (gap >= 0) begin
            return DUTY_OFF;
        end else if (gap >= GAP_FULL_LO && gap <= GAP_FULL_HI) begin
            return DUTY_FULL;
        end else if (gap == GAP_MID) begin
            return DUTY_MID + extra;
        end else begin
            return DUTY_LOW + extra;
        end
    endfunction

endpackage

// ===== rtl/thermistor_fan_duty_controller_top.sv =====
// Thermistor fan duty controller: goal byte handling, fan duty update and
// ADC-to-temperature conversion through a bit-serial divider.
// Depends on tfdc_pkg.
//
//  Channel | Direction | Ports                         | Contents
//  --------+-----------+-------------------------------+------------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | command, adc_sample, rx_byte
//  m_      | out       | m_tvalid m_tready m_tdata     | fan_duty, led_on, tx_byte, temperature
//
// A goal transaction offers its result in the cycle after it is accepted; an ADC transaction
// passes through the LOAD, DIV, PROD, DIFF and ROUND states first, the restoring divider in
// DIV retiring one quotient bit per cycle. One item is in flight at a time: s_tready is high
// only when idle, from the cycle after the result is taken, and a result holds on m_tdata until
// m_tready takes it. Synchronous active-low reset clears the goal, temperature, duty
// and LED state and returns the sequencer to idle.
module thermistor_fan_duty_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [11:0] adc_sample, [19:12] rx_byte, upper bits zero
    input  logic [tfdc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] fan_duty, [8] led_on, [16:9] tx_byte, [38:17] temperature, upper bits zero
    output logic [tfdc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int ADC_BITS = tfdc_pkg::ADC_BITS;
    localparam int NUM_W    = tfdc_pkg::NUM_W;
    localparam int DEN_W    = tfdc_pkg::DEN_W;
    localparam int CNT_W    = tfdc_pkg::CNT_W;
    localparam int PROD_W   = tfdc_pkg::PROD_W;
    localparam int Q_W      = tfdc_pkg::Q_W;
    localparam int TEMP_W   = tfdc_pkg::TEMP_W;
    localparam int BYTE_W   = tfdc_pkg::BYTE_W;
    localparam int DUTY_W   = tfdc_pkg::DUTY_W;
    localparam int SLOPE_W  = tfdc_pkg::SLOPE_W;
    localparam int FRAC_W   = tfdc_pkg::FRAC_W;

    tfdc_pkg::state_t state_reg, state_next;

    logic [BYTE_W-1:0]        goal_reg;
    logic                     goal_valid_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [DUTY_W-1:0]        duty_reg;
    logic                     led_reg;
    logic [BYTE_W-1:0]        tx_reg;
    logic [ADC_BITS-1:0]      adc_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [Q_W-1:0]    q_reg;

    logic                     s_fire;
    logic                     m_fire;
    logic [ADC_BITS-1:0]      in_adc;
    logic [BYTE_W-1:0]        in_rx;
    logic [DEN_W:0]           rem_shift;
    logic [DEN_W:0]           den_ext;
    logic [DEN_W:0]           rem_sub;
    logic                     div_ge;
    logic [SLOPE_W-1:0]       slope_sel;
    logic signed [Q_W-1:0]    offs_sel;
    logic signed [Q_W-1:0]    q_adj;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign in_adc = s_tdata[ADC_BITS-1:0];
    assign in_rx  = s_tdata[ADC_BITS +: BYTE_W];

    // One restoring division step: the quotient bit shifts into num_reg as the
    // dividend bit shifts out.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign den_ext   = {1'b0, den_reg};
    assign div_ge    = rem_shift >= den_ext;
    assign rem_sub   = rem_shift - den_ext;

    // Segment of the temperature law, chosen from the resistance in num_reg.
    always_comb begin
        if (num_reg >= tfdc_pkg::R_A_LO && num_reg <= tfdc_pkg::R_A_HI) begin
            slope_sel = tfdc_pkg::SLOPE_A;
            offs_sel  = tfdc_pkg::OFFS_A;
        end else if (num_reg >= tfdc_pkg::R_B_LO && num_reg < tfdc_pkg::R_A_LO) begin
            slope_sel = tfdc_pkg::SLOPE_B;
            offs_sel  = tfdc_pkg::OFFS_B;
        end else begin
            slope_sel = tfdc_pkg::SLOPE_C;
            offs_sel  = tfdc_pkg::OFFS_C;
        end
    end

    // Bias negative values so the arithmetic shift truncates toward zero.
    assign q_adj = q_reg[Q_W-1] ? (q_reg + tfdc_pkg::TRUNC_BIAS) : q_reg;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfdc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == tfdc_pkg::CMD_GOAL) ? tfdc_pkg::ST_DONE
                                                                 : tfdc_pkg::ST_LOAD;
                end
            end
            tfdc_pkg::ST_LOAD:  state_next = tfdc_pkg::ST_DIV;
            tfdc_pkg::ST_DIV: begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = tfdc_pkg::ST_PROD;
                end
            end
            tfdc_pkg::ST_PROD:  state_next = tfdc_pkg::ST_DIFF;
            tfdc_pkg::ST_DIFF:  state_next = tfdc_pkg::ST_ROUND;
            tfdc_pkg::ST_ROUND: state_next = tfdc_pkg::ST_DONE;
            tfdc_pkg::ST_DONE: begin
                if (m_fire) begin
                    state_next = tfdc_pkg::ST_IDLE;
                end
            end
            default: state_next = tfdc_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_tready = (state_reg == tfdc_pkg::ST_IDLE);
        m_tvalid = (state_reg == tfdc_pkg::ST_DONE);
    end

    assign m_tdata = {{(tfdc_pkg::OUT_TDATA_W - tfdc_pkg::OUT_BITS){1'b0}},
                      temp_reg, tx_reg, led_reg, duty_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tfdc_pkg::ST_IDLE;
            goal_reg       <= '0;
            goal_valid_reg <= 1'b0;
            temp_reg       <= '0;
            duty_reg       <= '0;
            led_reg        <= 1'b0;
            tx_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                if (s_tuser == tfdc_pkg::CMD_GOAL) begin
                    tx_reg         <= temp_reg[BYTE_W-1:0];
                    goal_reg       <= in_rx;
                    goal_valid_reg <= 1'b1;
                end else begin
                    tx_reg <= '0;
                    // Duty follows the temperature from before this sample.
                    if (goal_valid_reg) begin
                        duty_reg <= tfdc_pkg::fan_level(goal_reg, temp_reg);
                    end
                    led_reg <= (in_adc >= tfdc_pkg::LED_THRESH);
                end
            end
            if (state_reg == tfdc_pkg::ST_ROUND) begin
                temp_reg <= q_adj[FRAC_W +: TEMP_W];
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        case (state_reg)
            tfdc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    adc_reg <= in_adc;
                end
            end
            tfdc_pkg::ST_LOAD: begin
                num_reg <= {{tfdc_pkg::RSCALE_W{1'b0}}, adc_reg}
                         * {{ADC_BITS{1'b0}}, tfdc_pkg::RSCALE};
                den_reg <= tfdc_pkg::ADC_FULL - {1'b0, adc_reg};
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            tfdc_pkg::ST_DIV: begin
                num_reg <= {num_reg[NUM_W-2:0], div_ge};
                rem_reg <= div_ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            tfdc_pkg::ST_PROD: begin
                prod_reg <= {{NUM_W{1'b0}}, slope_sel} * {{SLOPE_W{1'b0}}, num_reg};
            end
            tfdc_pkg::ST_DIFF: begin
                q_reg <= offs_sel - $signed({2'b00, prod_reg});
            end
            default: begin
            end
        endcase
    end

endmodule
